FILE: rtl/core/lsi_pkg.sv
// Shared types, codes and field widths for the indexed LIFO stack.
package lsi_pkg;

	localparam int CMD_W  = 3;
	localparam int WORD_W = 32;
	localparam int POS_W  = 5;
	localparam int STAT_W = 2;

	typedef logic [CMD_W-1:0]  cmd_t;
	typedef logic [STAT_W-1:0] stat_code_t;
	typedef logic signed [WORD_W-1:0] word_t;

	localparam cmd_t CMD_PUSH   = 3'd0;
	localparam cmd_t CMD_POP    = 3'd1;
	localparam cmd_t CMD_PEEK   = 3'd2;
	localparam cmd_t CMD_UPDATE = 3'd3;
	localparam cmd_t CMD_DUMP   = 3'd4;

	localparam stat_code_t STAT_OK       = 2'd0;
	localparam stat_code_t STAT_OVERFLOW = 2'd1;
	localparam stat_code_t STAT_EMPTY    = 2'd2;
	localparam stat_code_t STAT_BADPOS   = 2'd3;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RESP,
		ST_DUMP
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accept;
		logic load_resp;
		logic load_dump;
		logic dump_next;
	} ctrl_cmd_t;

	// Status from the datapath back to the controller.
	typedef struct packed {
		logic empty;
		logic ptr_zero;
		logic out_free;
	} dp_stat_t;

endpackage

FILE: rtl/core/lsi_ctrl.sv
// Controller state machine of the indexed LIFO stack.
module lsi_ctrl
	import lsi_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  cmd_t      cmd,
	input  dp_stat_t  stat,
	output logic      in_ready,
	output ctrl_cmd_t ctl
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		in_ready      = 1'b0;
		ctl           = '0;
		case (state_q)
			ST_IDLE: begin
				in_ready   = 1'b1;
				ctl.accept = in_valid;
				if (in_valid) begin
					if (cmd == CMD_DUMP && !stat.empty) begin
						state_d = ST_DUMP;
					end else begin
						state_d = ST_RESP;
					end
				end
			end
			ST_RESP: begin
				if (stat.out_free) begin
					ctl.load_resp = 1'b1;
					state_d       = ST_IDLE;
				end
			end
			ST_DUMP: begin
				if (stat.out_free) begin
					ctl.load_dump = 1'b1;
					if (stat.ptr_zero) begin
						state_d = ST_IDLE;
					end else begin
						ctl.dump_next = 1'b1;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

FILE: rtl/core/lsi_dp.sv
// Datapath of the indexed LIFO stack: entry memory, count, output register.
module lsi_dp
	import lsi_pkg::*;
#(
	parameter int DEPTH = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  ctrl_cmd_t  ctl,
	input  cmd_t       cmd,
	input  word_t      push_value,
	input  logic [POS_W-1:0] position,
	input  logic       out_ready,
	output dp_stat_t   stat,
	output logic       out_valid,
	output stat_code_t out_status,
	output word_t      out_data,
	output logic       out_last
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam int XW = (CW > POS_W) ? CW : POS_W;

	word_t mem [DEPTH];
	word_t rdata_q;

	logic [CW-1:0] count_q, count_d;
	logic [AW-1:0] ptr_q;
	stat_code_t    status_q;
	logic          use_rd_q;
	logic          out_valid_q;
	stat_code_t    out_status_q;
	word_t         out_data_q;
	logic          out_last_q;

	logic          full, empty, pos_bad;
	logic [XW-1:0] pos_x, cnt_x;
	logic [AW-1:0] slot, top_slot;
	logic          we, re;
	logic [AW-1:0] waddr, raddr;
	stat_code_t    status_d;
	logic          use_rd_d;

	assign full     = (count_q == CW'(DEPTH));
	assign empty    = (count_q == '0);
	assign pos_x    = XW'(position);
	assign cnt_x    = XW'(count_q);
	assign pos_bad  = (pos_x == '0) || (pos_x > cnt_x);
	assign slot     = AW'(cnt_x - pos_x);
	assign top_slot = AW'(count_q - CW'(1));

	// Decode of the accepted command.
	always_comb begin
		we       = 1'b0;
		re       = 1'b0;
		waddr    = slot;
		raddr    = top_slot;
		count_d  = count_q;
		status_d = STAT_OK;
		use_rd_d = 1'b0;
		case (cmd)
			CMD_PUSH: begin
				if (full) begin
					status_d = STAT_OVERFLOW;
				end else begin
					we      = 1'b1;
					waddr   = AW'(count_q);
					count_d = count_q + CW'(1);
				end
			end
			CMD_POP: begin
				if (empty) begin
					status_d = STAT_EMPTY;
				end else begin
					re       = 1'b1;
					use_rd_d = 1'b1;
					count_d  = count_q - CW'(1);
				end
			end
			CMD_PEEK: begin
				if (pos_bad) begin
					status_d = STAT_BADPOS;
				end else begin
					re       = 1'b1;
					raddr    = slot;
					use_rd_d = 1'b1;
				end
			end
			CMD_UPDATE: begin
				if (pos_bad) begin
					status_d = STAT_BADPOS;
				end else begin
					we = 1'b1;
				end
			end
			CMD_DUMP: begin
				if (empty) begin
					status_d = STAT_EMPTY;
				end else begin
					re = 1'b1;
				end
			end
			default: begin
				status_d = STAT_OK;
			end
		endcase
		if (!ctl.accept) begin
			we      = 1'b0;
			re      = 1'b0;
			count_d = count_q;
		end
		if (ctl.dump_next) begin
			re    = 1'b1;
			raddr = ptr_q - AW'(1);
		end
	end

	// Entry memory with one write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= push_value;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			count_q <= count_d;
			if (ctl.load_resp || ctl.load_dump) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.accept) begin
			status_q <= status_d;
			use_rd_q <= use_rd_d;
			ptr_q    <= top_slot;
		end else if (ctl.dump_next) begin
			ptr_q <= ptr_q - AW'(1);
		end
		if (ctl.load_resp) begin
			out_status_q <= status_q;
			out_data_q   <= use_rd_q ? rdata_q : '0;
			out_last_q   <= 1'b1;
		end else if (ctl.load_dump) begin
			out_status_q <= STAT_OK;
			out_data_q   <= rdata_q;
			out_last_q   <= (ptr_q == '0);
		end
	end

	assign stat.empty    = empty;
	assign stat.ptr_zero = (ptr_q == '0);
	assign stat.out_free = !out_valid_q || out_ready;

	assign out_valid  = out_valid_q;
	assign out_status = out_status_q;
	assign out_data   = out_data_q;
	assign out_last   = out_last_q;

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("stack count exceeds depth");

	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.accept && cmd == CMD_PUSH && !full |=> count_q == $past(count_q) + CW'(1))
		else $error("accepted push did not grow the stack");

	a_dump_body_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_last_q |-> out_status_q == STAT_OK)
		else $error("non-final dump result carries an error status");

	a_no_load_when_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready |-> !(ctl.load_resp || ctl.load_dump))
		else $error("output register overwritten while stalled");

endmodule

FILE: rtl/core/lifo_stack_with_indexed_access.sv
// Top level of the fixed-depth LIFO stack with indexed peek, update and dump.
//
// Usage:
// Commands arrive on the slave stream (s_tvalid/s_tready/s_tdata); each item
// carries a command code, a value and a position. Results leave on the master
// stream (m_tvalid/m_tready/m_tdata/m_tlast) as status plus data, with tlast
// marking the final result of a command.
// Push, pop, peek, update and unused codes give one result each. A dump of a
// non-empty stack gives one result per stored entry, top entry first.
// Order: an accepted item has its status registered and, where it reads the
// stack, its entry read; its result is then loaded into the output register
// from the response state, and the input takes no new item until that load
// is done. A dump loads one result per stored entry, each read before it is
// loaded. This order comes from the registered read port of the entry memory,
// whose word must be read before it can be loaded into the output register.
// When the receiver stalls, the result is held in the output register. The
// controller still takes one more item and keeps its result waiting; no item
// after that is taken until the held result has moved on.
// Reset clears the entry count and the output valid; entry contents are left
// as they were and are only ever read after being written by a push.
module lifo_stack_with_indexed_access
	import lsi_pkg::*;
#(
	parameter int DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// From bit 0: cmd[2:0], push_value[34:3], position[39:35].
	input  logic [39:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// From bit 0: status[1:0], data[33:2], zero padding[39:34].
	output logic [39:0] m_tdata,
	output logic        m_tlast
);

	ctrl_cmd_t  ctl;
	dp_stat_t   stat;
	cmd_t       cmd;
	word_t      push_value;
	logic [POS_W-1:0] position;
	stat_code_t out_status;
	word_t      out_data;

	// Unpack the command item.
	assign cmd        = s_tdata[CMD_W-1:0];
	assign push_value = s_tdata[CMD_W+WORD_W-1:CMD_W];
	assign position   = s_tdata[CMD_W+WORD_W+POS_W-1:CMD_W+WORD_W];

	lsi_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.cmd      (cmd),
		.stat     (stat),
		.in_ready (s_tready),
		.ctl      (ctl)
	);

	lsi_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.cmd        (cmd),
		.push_value (push_value),
		.position   (position),
		.out_ready  (m_tready),
		.stat       (stat),
		.out_valid  (m_tvalid),
		.out_status (out_status),
		.out_data   (out_data),
		.out_last   (m_tlast)
	);

	// Pack the result item; the upper bits are zero padding to whole bytes.
	assign m_tdata = {6'd0, out_data, out_status};

endmodule
